[design/lcd_scanline_timing_controller_defines.svh]
// ----------------------------------------------------------------------------
// lcd scanline timing controller assertion macros
// concurrent checks on clock, with or without the reset qualifier
// ----------------------------------------------------------------------------
`ifndef LCD_SCANLINE_TIMING_CONTROLLER_DEFINES_SVH
`define LCD_SCANLINE_TIMING_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LSTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LSTC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LSTC_ASSERT(lbl, prop, msg)
`define LSTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/lstc_pkg.sv]
// ----------------------------------------------------------------------------
// lstc_pkg
// constants of the lcd scanline timing controller: operations, modes,
// register map, reset values, status bit positions and line timing
// ----------------------------------------------------------------------------
`default_nettype none

package lstc_pkg;

   localparam int LINE_DOTS_DEFAULT     = 456;
   localparam int VISIBLE_LINES_DEFAULT = 144;

   localparam logic [7:0] LAST_LINE     = 8'd153;
   localparam logic [8:0] OAM_END       = 9'd80;
   localparam logic [8:0] TRANSFER_END  = 9'd252;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [1:0] MODE_HBLANK   = 2'd0;
   localparam logic [1:0] MODE_VBLANK   = 2'd1;
   localparam logic [1:0] MODE_OAM      = 2'd2;
   localparam logic [1:0] MODE_TRANSFER = 2'd3;

   localparam logic [7:0] REG_PAGE  = 8'hFF;
   localparam logic [7:0] REG_LCDC  = 8'h40;
   localparam logic [7:0] REG_STAT  = 8'h41;
   localparam logic [7:0] REG_SCY   = 8'h42;
   localparam logic [7:0] REG_SCX   = 8'h43;
   localparam logic [7:0] REG_LY    = 8'h44;
   localparam logic [7:0] REG_LYC   = 8'h45;
   localparam logic [7:0] REG_BGP   = 8'h47;
   localparam logic [7:0] REG_OBP0  = 8'h48;
   localparam logic [7:0] REG_OBP1  = 8'h49;
   localparam logic [7:0] REG_WY    = 8'h4A;
   localparam logic [7:0] REG_WX    = 8'h4B;

   localparam logic [7:0] LCDC_RESET = 8'h91;
   localparam logic [6:0] STAT_RESET = 7'h05;
   localparam logic [7:0] BGP_RESET  = 8'hFC;
   localparam logic [7:0] OBP_RESET  = 8'hFF;
   localparam logic [7:0] UNMAPPED   = 8'hFF;

   // status bit positions
   localparam int STAT_COINC   = 2;
   localparam int STAT_EN_HBL  = 3;
   localparam int STAT_EN_VBL  = 4;
   localparam int STAT_EN_OAM  = 5;
   localparam int STAT_EN_LYC  = 6;

endpackage

`default_nettype wire

[design/lcd_scanline_timing_controller.sv]
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller
// a request is held in the request register, and its result then moves
// into the response register; throughput: one item per cycle while the
// response is not stalled, set by the single update stage between the two registers
// reset: synchronous; valid flags clear and lcd state registers return to power-on values, lcd on, line 0
// ----------------------------------------------------------------------------
`default_nettype none
`include "lcd_scanline_timing_controller_defines.svh"

module lcd_scanline_timing_controller #(
   parameter int LINE_DOTS     = lstc_pkg::LINE_DOTS_DEFAULT,
   parameter int VISIBLE_LINES = lstc_pkg::VISIBLE_LINES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_dots,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_vblank_irq,
   output logic             rsp_stat_irq,
   output logic             rsp_line_done,
   output logic [7:0]       rsp_current_line,
   output logic [1:0]       rsp_current_mode
);

   import lstc_pkg::*;

   localparam logic [9:0] LINE_DOTS_W = 10'(LINE_DOTS);
   localparam logic [7:0] VIS_LINE    = 8'(VISIBLE_LINES);

   // request register
   logic        in_vld_ff;
   logic [1:0]  op_ff;
   logic [7:0]  dots_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff;

   // response register
   logic        out_vld_ff;
   logic [7:0]  rd_ff;
   logic        vbl_ff;
   logic        sti_ff;
   logic        done_ff;

   // lcd state
   logic [7:0]  lcdc_ff, lcdc_in;
   logic [6:0]  stat_ff, stat_in;
   logic [7:0]  scy_ff, scy_in;
   logic [7:0]  scx_ff, scx_in;
   logic [7:0]  ly_ff, ly_in;
   logic [7:0]  lyc_ff, lyc_in;
   logic [7:0]  bgp_ff, bgp_in;
   logic [7:0]  obp0_ff, obp0_in;
   logic [7:0]  obp1_ff, obp1_in;
   logic [7:0]  wy_ff, wy_in;
   logic [7:0]  wx_ff, wx_in;
   logic        hit_ff, hit_in;
   logic [8:0]  dot_ff, dot_in;

   logic        advance;
   logic        take;
   logic [9:0]  dot_sum;
   logic [1:0]  mode_tgt;
   logic [7:0]  rd_in;
   logic        vbl_in;
   logic        sti_in;
   logic        done_in;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign rsp_valid        = out_vld_ff;
   assign rsp_read_data    = rd_ff;
   assign rsp_vblank_irq   = vbl_ff;
   assign rsp_stat_irq     = sti_ff;
   assign rsp_line_done    = done_ff;
   assign rsp_current_line = ly_ff;
   assign rsp_current_mode = stat_ff[1:0];

   assign dot_sum = {1'b0, dot_ff} + {2'b00, dots_ff};

   always_comb begin
      lcdc_in = lcdc_ff;
      stat_in = stat_ff;
      scy_in  = scy_ff;
      scx_in  = scx_ff;
      ly_in   = ly_ff;
      lyc_in  = lyc_ff;
      bgp_in  = bgp_ff;
      obp0_in = obp0_ff;
      obp1_in = obp1_ff;
      wy_in   = wy_ff;
      wx_in   = wx_ff;
      hit_in  = hit_ff;
      dot_in  = dot_ff;
      rd_in   = 8'h00;
      vbl_in  = 1'b0;
      sti_in  = 1'b0;
      done_in = 1'b0;
      mode_tgt = MODE_HBLANK;
      case (op_ff)
         OP_TICK: begin
            if (!lcdc_ff[7]) begin
               dot_in = '0;
               ly_in  = '0;
               if (stat_in[1:0] != MODE_HBLANK) begin
                  stat_in[1:0] = MODE_HBLANK;
                  if (stat_in[STAT_EN_HBL]) sti_in = 1'b1;
               end
               if (!stat_in[STAT_COINC] && (ly_in == lyc_ff) && stat_in[STAT_EN_LYC])
                  sti_in = 1'b1;
               stat_in[STAT_COINC] = (ly_in == lyc_ff);
            end else begin
               if (dot_sum >= LINE_DOTS_W) begin
                  dot_in = 9'(dot_sum - LINE_DOTS_W);
                  ly_in  = ly_ff + 8'd1;
                  if (!stat_in[STAT_COINC] && (ly_in == lyc_ff) && stat_in[STAT_EN_LYC])
                     sti_in = 1'b1;
                  stat_in[STAT_COINC] = (ly_in == lyc_ff);
                  if (ly_in == wy_ff) hit_in = 1'b1;
                  if (ly_in == VIS_LINE) begin
                     hit_in = 1'b0;
                     if (stat_in[1:0] != MODE_VBLANK) begin
                        stat_in[1:0] = MODE_VBLANK;
                        vbl_in = 1'b1;
                        if (stat_in[STAT_EN_VBL]) sti_in = 1'b1;
                     end
                  end else if (ly_in > LAST_LINE) begin
                     ly_in = '0;
                     if (stat_in[1:0] != MODE_OAM) begin
                        stat_in[1:0] = MODE_OAM;
                        if (stat_in[STAT_EN_OAM]) sti_in = 1'b1;
                     end
                     if (!stat_in[STAT_COINC] && (ly_in == lyc_ff) && stat_in[STAT_EN_LYC])
                        sti_in = 1'b1;
                     stat_in[STAT_COINC] = (ly_in == lyc_ff);
                  end
               end else begin
                  dot_in = dot_sum[8:0];
               end
               if (ly_in < VIS_LINE) begin
                  if (dot_in < OAM_END) begin
                     mode_tgt = MODE_OAM;
                  end else if (dot_in < TRANSFER_END) begin
                     mode_tgt = MODE_TRANSFER;
                  end else begin
                     mode_tgt = MODE_HBLANK;
                  end
                  if ((stat_ff[1:0] != MODE_HBLANK) && (mode_tgt == MODE_HBLANK))
                     done_in = 1'b1;
                  if (stat_in[1:0] != mode_tgt) begin
                     stat_in[1:0] = mode_tgt;
                     if ((mode_tgt == MODE_HBLANK) && stat_in[STAT_EN_HBL]) sti_in = 1'b1;
                     if ((mode_tgt == MODE_OAM) && stat_in[STAT_EN_OAM]) sti_in = 1'b1;
                  end
               end
               if (!stat_in[STAT_COINC] && (ly_in == lyc_ff) && stat_in[STAT_EN_LYC])
                  sti_in = 1'b1;
               stat_in[STAT_COINC] = (ly_in == lyc_ff);
            end
         end
         OP_READ: begin
            rd_in = UNMAPPED;
            if (addr_ff[15:8] == REG_PAGE) begin
               case (addr_ff[7:0])
                  REG_LCDC: rd_in = lcdc_ff;
                  REG_STAT: rd_in = {1'b1, stat_ff};
                  REG_SCY:  rd_in = scy_ff;
                  REG_SCX:  rd_in = scx_ff;
                  REG_LY:   rd_in = ly_ff;
                  REG_LYC:  rd_in = lyc_ff;
                  REG_BGP:  rd_in = bgp_ff;
                  REG_OBP0: rd_in = obp0_ff;
                  REG_OBP1: rd_in = obp1_ff;
                  REG_WY:   rd_in = wy_ff;
                  REG_WX:   rd_in = wx_ff;
                  default:  rd_in = UNMAPPED;
               endcase
            end
         end
         OP_WRITE: begin
            if (addr_ff[15:8] == REG_PAGE) begin
               case (addr_ff[7:0])
                  REG_LCDC: lcdc_in = wdata_ff;
                  REG_STAT: stat_in = {wdata_ff[6:3], stat_ff[2:0]};
                  REG_SCY:  scy_in  = wdata_ff;
                  REG_SCX:  scx_in  = wdata_ff;
                  REG_LY: begin
                     ly_in = '0;
                     if (!stat_ff[STAT_COINC] && (lyc_ff == 8'h00) && stat_ff[STAT_EN_LYC])
                        sti_in = 1'b1;
                     stat_in[STAT_COINC] = (lyc_ff == 8'h00);
                  end
                  REG_LYC: begin
                     lyc_in = wdata_ff;
                     if (!stat_ff[STAT_COINC] && (ly_ff == wdata_ff) && stat_ff[STAT_EN_LYC])
                        sti_in = 1'b1;
                     stat_in[STAT_COINC] = (ly_ff == wdata_ff);
                  end
                  REG_BGP:  bgp_in  = wdata_ff;
                  REG_OBP0: obp0_in = wdata_ff;
                  REG_OBP1: obp1_in = wdata_ff;
                  REG_WY:   wy_in   = wdata_ff;
                  REG_WX:   wx_in   = wdata_ff;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff    <= req_operation;
         dots_ff  <= req_dots;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
      if (advance) begin
         rd_ff   <= rd_in;
         vbl_ff  <= vbl_in;
         sti_ff  <= sti_in;
         done_ff <= done_in;
      end
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         lcdc_ff    <= LCDC_RESET;
         stat_ff    <= STAT_RESET;
         scy_ff     <= '0;
         scx_ff     <= '0;
         ly_ff      <= '0;
         lyc_ff     <= '0;
         bgp_ff     <= BGP_RESET;
         obp0_ff    <= OBP_RESET;
         obp1_ff    <= OBP_RESET;
         wy_ff      <= '0;
         wx_ff      <= '0;
         hit_ff     <= 1'b0;
         dot_ff     <= '0;
      end else begin
         if (take) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
         if (advance) begin
            lcdc_ff <= lcdc_in;
            stat_ff <= stat_in;
            scy_ff  <= scy_in;
            scx_ff  <= scx_in;
            ly_ff   <= ly_in;
            lyc_ff  <= lyc_in;
            bgp_ff  <= bgp_in;
            obp0_ff <= obp0_in;
            obp1_ff <= obp1_in;
            wy_ff   <= wy_in;
            wx_ff   <= wx_in;
            hit_ff  <= hit_in;
            dot_ff  <= dot_in;
         end
      end
   end

   // assertions
   `LSTC_ASSERT(a_dot_in_line, ({1'b0, dot_ff} < LINE_DOTS_W), "dot counter past line end")
   `LSTC_ASSERT(a_coinc_tracks, (stat_ff[STAT_COINC] == (ly_ff == lyc_ff)), "coincidence bit stale")
   `LSTC_ASSERT(a_done_hblank, (rsp_valid && rsp_line_done) |-> (rsp_current_mode == MODE_HBLANK), "line done outside hblank")
   `LSTC_ASSERT(a_vbl_mode, (rsp_valid && rsp_vblank_irq) |-> (rsp_current_mode == MODE_VBLANK), "vblank request outside vblank")

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: lcd scanline timing controller bench
// drives ticks, register reads, register writes and unused operations through the
// request channel with random gaps and response stalls, predicts line, mode,
// interrupt and read data for every transfer, and compares each response
// field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
   import lstc_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [7:0] REG_HOLE    = 8'h46;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         RANDOM_ITEMS = 1750;
   localparam int         CALM_ITEMS  = 250;

   typedef struct {
      logic [1:0]  operation;
      logic [7:0]  dots;
      logic [15:0] address;
      logic [7:0]  write_data;
   } lcd_req_type;

   typedef struct {
      logic [7:0] read_data;
      logic       vblank_irq;
      logic       stat_irq;
      logic       line_done;
      logic [7:0] line;
      logic [1:0] mode;
   } lcd_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_TICK;
   logic [7:0]  req_dots = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_vblank_irq;
   logic        rsp_stat_irq;
   logic        rsp_line_done;
   logic [7:0]  rsp_current_line;
   logic [1:0]  rsp_current_mode;

   lcd_scanline_timing_controller DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted register file and line timing
   logic [7:0] lcdc, scy, scx, ly, lyc, bgp, obp0, obp1, wy, wx;
   logic [6:0] stat;
   logic       window_hit;
   int         dot_count;
   logic       vblank_req, stat_req;

   lcd_req_type bus_items[$];
   lcd_rsp_type due_responses[$];
   int       items_queued = 0;
   int       items_accepted = 0;
   int       fail_count = 0;
   int       cycle_count = 0;
   int       gap_left = 0;
   int       stall_left = 0;
   logic     req_taken = 1'b0;
   logic     calm = 1'b0;

   logic [7:0] reg_offsets [12] = '{REG_LCDC, REG_STAT, REG_SCY, REG_SCX, REG_LY, REG_LYC,
                                    REG_HOLE, REG_BGP, REG_OBP0, REG_OBP1, REG_WY, REG_WX};

   function void update_coincidence();
      logic was;
      was = stat[STAT_COINC];
      stat[STAT_COINC] = (ly == lyc);
      if (!was && stat[STAT_COINC] && stat[STAT_EN_LYC]) stat_req = 1'b1;
   endfunction

   function void switch_mode(logic [1:0] mode);
      if (stat[1:0] != mode) begin
         stat[1:0] = mode;
         case (mode)
            MODE_HBLANK: if (stat[STAT_EN_HBL]) stat_req = 1'b1;
            MODE_VBLANK: begin
               vblank_req = 1'b1;
               if (stat[STAT_EN_VBL]) stat_req = 1'b1;
            end
            MODE_OAM: if (stat[STAT_EN_OAM]) stat_req = 1'b1;
            default: ;
         endcase
      end
   endfunction

   function automatic lcd_rsp_type lcd_timing_step(lcd_req_type r);
      lcd_rsp_type o;
      logic [1:0]  start_mode;
      logic [1:0]  line_mode;
      o.read_data = '0;
      o.line_done = 1'b0;
      vblank_req = 1'b0;
      stat_req = 1'b0;
      start_mode = stat[1:0];
      case (r.operation)
         OP_TICK: begin
            if (!lcdc[7]) begin
               dot_count = 0;
               ly = '0;
               switch_mode(MODE_HBLANK);
            end else begin
               dot_count += r.dots;
               while (dot_count >= LINE_DOTS_DEFAULT) begin
                  dot_count -= LINE_DOTS_DEFAULT;
                  ly = ly + 8'd1;
                  update_coincidence();
                  if (ly == wy) window_hit = 1'b1;
                  if (ly == VISIBLE_LINES_DEFAULT) begin
                     window_hit = 1'b0;
                     switch_mode(MODE_VBLANK);
                  end else if (ly > LAST_LINE) begin
                     ly = '0;
                     switch_mode(MODE_OAM);
                     update_coincidence();
                  end
               end
               if (ly < VISIBLE_LINES_DEFAULT) begin
                  if (dot_count < OAM_END) line_mode = MODE_OAM;
                  else if (dot_count < TRANSFER_END) line_mode = MODE_TRANSFER;
                  else line_mode = MODE_HBLANK;
                  o.line_done = (start_mode != MODE_HBLANK) && (line_mode == MODE_HBLANK);
                  switch_mode(line_mode);
               end
            end
            update_coincidence();
         end
         OP_READ: begin
            o.read_data = UNMAPPED;
            if (r.address[15:8] == REG_PAGE) begin
               case (r.address[7:0])
                  REG_LCDC: o.read_data = lcdc;
                  REG_STAT: o.read_data = {1'b1, stat};
                  REG_SCY:  o.read_data = scy;
                  REG_SCX:  o.read_data = scx;
                  REG_LY:   o.read_data = ly;
                  REG_LYC:  o.read_data = lyc;
                  REG_BGP:  o.read_data = bgp;
                  REG_OBP0: o.read_data = obp0;
                  REG_OBP1: o.read_data = obp1;
                  REG_WY:   o.read_data = wy;
                  REG_WX:   o.read_data = wx;
                  default: ;
               endcase
            end
         end
         OP_WRITE: begin
            if (r.address[15:8] == REG_PAGE) begin
               case (r.address[7:0])
                  REG_LCDC: lcdc = r.write_data;
                  REG_STAT: stat[6:3] = r.write_data[6:3];
                  REG_SCY:  scy = r.write_data;
                  REG_SCX:  scx = r.write_data;
                  REG_LY: begin
                     ly = '0;
                     update_coincidence();
                  end
                  REG_LYC: begin
                     lyc = r.write_data;
                     update_coincidence();
                  end
                  REG_BGP:  bgp = r.write_data;
                  REG_OBP0: obp0 = r.write_data;
                  REG_OBP1: obp1 = r.write_data;
                  REG_WY:   wy = r.write_data;
                  REG_WX:   wx = r.write_data;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      o.vblank_irq = vblank_req;
      o.stat_irq = stat_req;
      o.line = ly;
      o.mode = stat[1:0];
      return o;
   endfunction

   function void queue_item(logic [1:0] op, logic [7:0] dots, logic [15:0] address,
                            logic [7:0] data);
      lcd_req_type item;
      item.operation = op;
      item.dots = dots;
      item.address = address;
      item.write_data = data;
      bus_items.push_back(item);
      items_queued++;
   endfunction

   function void check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, expected, actual);
         fail_count++;
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      lcd_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bus_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 7) begin
            gap_left = $urandom_range(0, 16);
            req_valid <= 1'b0;
         end else begin
            item = bus_items.pop_front();
            req_operation <= item.operation;
            req_dots <= item.dots;
            req_address <= item.address;
            req_write_data <= item.write_data;
            req_valid <= 1'b1;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 7) begin
         stall_left = $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // prediction on request transfer, comparison on response transfer
   always @(posedge clock) begin
      lcd_req_type seen;
      lcd_rsp_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.operation = req_operation;
            seen.dots = req_dots;
            seen.address = req_address;
            seen.write_data = req_write_data;
            due_responses.push_back(lcd_timing_step(seen));
            items_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               $error("response transfer with nothing outstanding");
               fail_count++;
            end else begin
               want = due_responses.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("vblank_irq", want.vblank_irq, rsp_vblank_irq);
               check_field("stat_irq", want.stat_irq, rsp_stat_irq);
               check_field("line_done", want.line_done, rsp_line_done);
               check_field("current_line", want.line, rsp_current_line);
               check_field("current_mode", want.mode, rsp_current_mode);
            end
         end
      end
      req_taken <= req_valid && !req_stall && !reset;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL lcd_scanline_timing_controller");
      $finish;
   end

   initial begin
      int         sel;
      int         r;
      logic [7:0] dots;
      logic [15:0] addr;
      logic [7:0] data;
      logic [7:0] pick;

      lcdc = LCDC_RESET;
      stat = STAT_RESET;
      scy = '0;
      scx = '0;
      ly = '0;
      lyc = '0;
      bgp = BGP_RESET;
      obp0 = OBP_RESET;
      obp1 = OBP_RESET;
      wy = '0;
      wx = '0;
      window_hit = 1'b0;
      dot_count = 0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: unused op, status enables, coincidence, mode walk, lcd off
      queue_item(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_STAT}, 8'hFF);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_LYC}, 8'h01);
      queue_item(OP_TICK, 8'h00, 16'h0000, 8'h00);
      queue_item(OP_TICK, 8'hFF, 16'h0000, 8'h00);
      queue_item(OP_TICK, 8'hFF, 16'hFFFF, 8'hFF);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_LY}, 8'hAB);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_SCY}, 8'hFF);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_WX}, 8'hFF);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_BGP}, 8'h00);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_HOLE}, 8'h12);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_LCDC}, 8'h00);
      queue_item(OP_TICK, 8'hFF, 16'h0000, 8'h00);
      queue_item(OP_WRITE, 8'h00, {REG_PAGE, REG_LCDC}, 8'hFF);
      queue_item(OP_READ, 8'h00, 16'hFFFF, 8'h00);
      for (int i = 0; i < 12; i++) queue_item(OP_READ, 8'h00, {REG_PAGE, reg_offsets[i]}, 8'h00);

      wait (items_accepted == items_queued && due_responses.size() == 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2)
            wait (items_accepted == items_queued && due_responses.size() == 0);
         if (n == RANDOM_ITEMS - CALM_ITEMS) begin
            wait (bus_items.size() == 0);
            calm = 1'b1;
         end
         sel = $urandom_range(0, 1999);
         dots = $urandom_range(0, 255);
         addr = $urandom_range(0, 65535);
         data = $urandom_range(0, 255);
         pick = reg_offsets[$urandom_range(0, 11)];
         if (sel < 1560) begin
            // mostly long ticks so that frames reach vblank and wrap
            r = $urandom_range(0, 99);
            if (r < 78) dots = $urandom_range(200, 255);
            else if (r < 88) dots = $urandom_range(0, 30);
            queue_item(OP_TICK, dots, addr, data);
         end else if (sel < 1760) begin
            if ($urandom_range(0, 5) != 0) addr = {REG_PAGE, pick};
            queue_item(OP_READ, dots, addr, data);
         end else if (sel < 1980) begin
            if ($urandom_range(0, 7) != 0) addr = {REG_PAGE, pick};
            if (addr == {REG_PAGE, REG_LY}) addr[7:0] = REG_LYC;
            if (addr == {REG_PAGE, REG_LCDC}) data[7] = 1'b1;
            if ((addr[7:0] == REG_LYC || addr[7:0] == REG_WY) && $urandom_range(0, 3) != 0)
               data = $urandom_range(0, LAST_LINE);
            queue_item(OP_WRITE, dots, addr, data);
         end else if (sel < 1998) begin
            queue_item(OP_UNUSED, dots, addr, data);
         end else if (sel == 1998) begin
            queue_item(OP_WRITE, dots, {REG_PAGE, REG_LY}, data);
         end else begin
            queue_item(OP_WRITE, dots, {REG_PAGE, REG_LCDC}, {1'b0, data[6:0]});
            queue_item(OP_TICK, dots, addr, data);
            queue_item(OP_WRITE, dots, {REG_PAGE, REG_LCDC}, {1'b1, data[6:0]});
         end
      end

      wait (items_accepted == items_queued);
      wait (due_responses.size() == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("PASS lcd_scanline_timing_controller");
      else
         $display("FAIL lcd_scanline_timing_controller");
      $finish;
   end

endmodule
